// ===== rtl/sgdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sgdt_pkg
// Shared codes and constants for the grain-drop sandpile toppler.
// ----------------------------------------------------------------------------
package sgdt_pkg;

    // Operation codes on i_operation
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_DROP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_RESV  = 2'd3;

    // Cell word: 0..16 grains while relaxing, all ones marks a wall
    localparam int          CELL_W     = 5;
    localparam logic [4:0]  CELL_WALL  = 5'h1F;
    localparam logic [4:0]  MAX_STABLE = 5'd8;

    // Topple counter
    localparam int          COUNT_W    = 20;
    localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;

endpackage

// ===== rtl/sgdt_ram.sv =====
// ----------------------------------------------------------------------------
// sgdt_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sgdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/sandpile_grain_drop_toppler.sv =====
// ----------------------------------------------------------------------------
// sandpile_grain_drop_toppler
// Sandpile grid in one RAM. Writes, reads and grain drops on single cells;
// an unstable drop is relaxed by repeated raster sweeps in which every cell
// above eight grains topples once, neighbor flags coming from a shift line.
// ----------------------------------------------------------------------------
// Sequencing: a write, the unused op or an off-grid target answers with busy low;
//   a read passes S_OUT; a drop without topple passes S_DROP; a cascading drop passes
//   S_DROP, runs sweeps (S_SWEEP, S_TAIL) until one finds no topple, then S_FIN, S_OUT.
// Throughput: the sweep is set by the RAM lead read port, one cell per cycle.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every cell
//   of the grid with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sandpile_grain_drop_toppler #(
    parameter int ROWS = 32,
    parameter int COLS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_operation,
    input  logic [4:0]         i_row,
    input  logic [4:0]         i_col,
    input  logic signed [4:0]  i_write_value,
    output logic               busy,
    output logic               o_valid,
    output logic signed [4:0]  o_cell_value,
    output logic [19:0]        o_topple_count
);
    import sgdt_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int JW    = $clog2(CELLS + COLS + 1);
    localparam int CW    = $clog2(COLS);
    localparam int SH    = 2 * COLS + 2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DROP, S_SWEEP, S_TAIL, S_FIN, S_OUT
    } t_state;

    t_state              r_state;
    logic [JW-1:0]       r_j;
    logic [CW-1:0]       r_lag_col;
    logic [AW-1:0]       r_addr;
    logic [COUNT_W-1:0]  r_count;
    logic                r_sweep_any;
    logic [SH-1:0]       r_tline;
    logic                r_valid;
    logic [CELL_W-1:0]   r_value;
    logic [COUNT_W-1:0]  r_out_count;

    // sweep pipeline: reads issued last cycle
    logic                r_p_run;
    logic                r_p_lead_ok;
    logic                r_p_lag_ok;
    logic [CW-1:0]       r_p_cm;
    logic [AW-1:0]       r_p_addr;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr_a;
    logic [AW-1:0]       ram_raddr_b;
    logic [CELL_W-1:0]   rdata_a;
    logic [CELL_W-1:0]   rdata_b;

    logic                accept;
    logic                in_range;
    logic [AW-1:0]       n_in_addr;
    logic [CELL_W-1:0]   n_wclamp;
    logic                t_lead;
    logic                t_self;
    logic                left_ok;
    logic                right_ok;
    logic [7:0]          nb;
    logic [CELL_W-1:0]   n_cell;
    logic                proc_we;
    logic                lead_ok;
    logic                lag_ok;
    logic [CELL_W-1:0]   drop_val;

    assign accept    = start && (r_state == S_IDLE);
    assign in_range  = (32'(i_row) < ROWS) && (32'(i_col) < COLS);
    assign n_in_addr = AW'(32'(i_row) * COLS + 32'(i_col));
    assign lead_ok   = r_j < JW'(CELLS);
    assign lag_ok    = r_j >= JW'(COLS + 1);
    assign drop_val  = rdata_a + 5'd1;

    // clamp the write value: negative makes a wall, above eight stores eight
    always_comb begin
        if (i_write_value < 0) begin
            n_wclamp = CELL_WALL;
        end else if (i_write_value > 5'sd8) begin
            n_wclamp = MAX_STABLE;
        end else begin
            n_wclamp = i_write_value;
        end
    end

    // topple flag of the lead cell and update of the lagging center cell
    assign t_lead   = r_p_run && r_p_lead_ok && (rdata_a != CELL_WALL) && (rdata_a > MAX_STABLE);
    assign t_self   = r_tline[COLS];
    assign left_ok  = r_p_cm != '0;
    assign right_ok = r_p_cm != CW'(COLS - 1);
    assign nb = {left_ok  & r_tline[2*COLS+1], r_tline[2*COLS], right_ok & r_tline[2*COLS-1],
                 left_ok  & r_tline[COLS+1],   right_ok & r_tline[COLS-1],
                 left_ok  & r_tline[1],        r_tline[0],    right_ok & t_lead};
    assign n_cell  = CELL_W'(6'(rdata_b) - (t_self ? 6'd8 : 6'd0) + 6'($countones(nb)));
    assign proc_we = r_p_run && r_p_lag_ok && (rdata_b != CELL_WALL);

    // RAM port selection
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_p_addr;
        ram_wdata   = n_cell;
        ram_raddr_a = r_addr;
        ram_raddr_b = AW'(r_j - JW'(COLS + 1));
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_raddr_a = n_in_addr;
                if (accept && i_operation == OP_WRITE && in_range) begin
                    ram_we    = 1'b1;
                    ram_waddr = n_in_addr;
                    ram_wdata = n_wclamp;
                end
            end
            S_DROP: begin
                if (rdata_a != CELL_WALL) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = drop_val;
                end
            end
            S_SWEEP: begin
                ram_raddr_a = r_j[AW-1:0];
            end
            default: begin
            end
        endcase
        if (proc_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_p_addr;
            ram_wdata = n_cell;
        end
    end

    sgdt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rdata_b)
    );

    // sequencer, sweep pipeline and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_j         <= '0;
            r_lag_col   <= '0;
            r_count     <= '0;
            r_sweep_any <= 1'b0;
            r_tline     <= '0;
            r_valid     <= 1'b0;
            r_p_run     <= 1'b0;
            r_p_lead_ok <= 1'b0;
            r_p_lag_ok  <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            // sweep processing side, working in the cycle after the issue side
            r_p_run <= 1'b0;
            if (r_p_run) begin
                r_tline <= {r_tline[SH-2:0], t_lead};
                if (t_lead) begin
                    r_sweep_any <= 1'b1;
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end

            case (r_state)
                S_CLEAR: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == JW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr  <= n_in_addr;
                        r_count <= '0;
                        if (!in_range || i_operation == OP_RESV) begin
                            r_valid     <= 1'b1;
                            r_value     <= '0;
                            r_out_count <= '0;
                        end else if (i_operation == OP_WRITE) begin
                            r_valid     <= 1'b1;
                            r_value     <= n_wclamp;
                            r_out_count <= '0;
                        end else if (i_operation == OP_DROP) begin
                            r_state <= S_DROP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DROP: begin
                    if (rdata_a == CELL_WALL || drop_val <= MAX_STABLE) begin
                        r_valid     <= 1'b1;
                        r_value     <= (rdata_a == CELL_WALL) ? CELL_WALL : drop_val;
                        r_out_count <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_j         <= '0;
                        r_lag_col   <= '0;
                        r_sweep_any <= 1'b0;
                        r_state     <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    // first issue of a sweep: nothing is being processed, clear the flags
                    if (r_j == '0) begin
                        r_tline <= '0;
                    end
                    // issue lead read at r_j, lagging read COLS+1 cells behind
                    r_p_run     <= 1'b1;
                    r_p_lead_ok <= lead_ok;
                    r_p_lag_ok  <= lag_ok;
                    r_p_cm      <= r_lag_col;
                    r_p_addr    <= AW'(r_j - JW'(COLS + 1));
                    if (lag_ok) begin
                        r_lag_col <= (r_lag_col == CW'(COLS - 1)) ? '0 : r_lag_col + 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                    if (r_j == JW'(CELLS + COLS)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    // last center is written here; its lead flag is always clear
                    if (r_sweep_any) begin
                        r_j         <= '0;
                        r_lag_col   <= '0;
                        r_sweep_any <= 1'b0;
                        r_state     <= S_SWEEP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid     <= 1'b1;
                    r_value     <= rdata_a;
                    r_out_count <= r_count;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_valid        = r_valid;
    assign o_cell_value   = r_value;
    assign o_topple_count = r_out_count;

endmodule

// ===== rtl/sgdt_checker.sv =====
// ----------------------------------------------------------------------------
// sgdt_checker
// Port-level checks on the sandpile toppler, bound to the top level.
// ----------------------------------------------------------------------------
module sgdt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic [1:0]         i_operation,
    input logic               busy,
    input logic               o_valid,
    input logic signed [4:0]  o_cell_value,
    input logic [19:0]        o_topple_count
);
    import sgdt_pkg::*;

    // writes and the unused code give their result in the next cycle and leave the block free
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == OP_WRITE || i_operation == OP_RESV)
        |=> o_valid && !busy)
        else $error("write or unused op did not complete in one cycle");

    // the unused code reports zeros
    a_resv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_RESV
        |=> o_cell_value == 5'sd0 && o_topple_count == 20'd0)
        else $error("unused op result not zero");

    // every reported cell is a wall or stable
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cell_value >= -5'sd1 && o_cell_value <= 5'sd8)
        else $error("cell value out of range");

    // topples only come from a relaxed drop, which ends on a stable non-wall cell
    a_topple_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_topple_count != 20'd0 |-> o_cell_value >= 5'sd0 && $past(busy))
        else $error("topple count on an unexpected result");

endmodule

bind sandpile_grain_drop_toppler sgdt_checker u_sgdt_checker (.*);

// ===== tb/sgdt_cell_checker.sv =====
// ----------------------------------------------------------------------------
// sgdt_cell_checker
// Watches the command and result channels of the sandpile toppler, keeps its
// own copy of the grid, relaxes it after every drop and compares each result
// strobe field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sgdt_cell_checker #(
    parameter int ROWS = 32,
    parameter int COLS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_operation,
    input  logic [4:0]         i_row,
    input  logic [4:0]         i_col,
    input  logic signed [4:0]  i_write_value,
    input  logic               i_valid,
    input  logic signed [4:0]  i_cell_value,
    input  logic [19:0]        i_topple_count,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sgdt_pkg::*;

    localparam int WALL         = -1;
    localparam int STABLE_LIMIT = int'(MAX_STABLE);
    localparam int TOPPLE_LOSS  = 9;

    typedef struct packed {
        logic signed [4:0] cell_value;
        logic [19:0]       topple_count;
    } t_cell_result;

    // Grain counts per cell, WALL for a wall
    int           grains [ROWS][COLS];
    t_cell_result awaited_results [$];
    int           mismatch_total = 0;
    int           awaited_count  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = awaited_count;

    task automatic report_mismatch(input string note);
        mismatch_total++;
        $display("%0t ns  MISMATCH: %s", $time, note);
    endtask

    function automatic void clear_grid();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                grains[r][c] = 0;
    endfunction

    // One grain to a cell; off-grid cells and walls swallow it
    function automatic void add_grain(input int r, input int c);
        if (r >= 0 && r < ROWS && c >= 0 && c < COLS && grains[r][c] != WALL) begin
            grains[r][c]++;
        end
    endfunction

    // Sweep until stable; topples are counted with saturation
    function automatic logic [19:0] settle_grid();
        logic [19:0] topples;
        bit          unstable;
        topples  = '0;
        unstable = 1'b1;
        while (unstable) begin
            unstable = 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    while (grains[r][c] > STABLE_LIMIT) begin
                        grains[r][c] -= TOPPLE_LOSS;
                        for (int dr = -1; dr <= 1; dr++)
                            for (int dc = -1; dc <= 1; dc++)
                                add_grain(r + dr, c + dc);
                        if (topples != COUNT_MAX) begin
                            topples++;
                        end
                        unstable = 1'b1;
                    end
                end
            end
        end
        return topples;
    endfunction

    // Apply one command to the grid copy and return the result it should give
    function automatic t_cell_result apply_cell_op(
        input logic [1:0]        op,
        input logic [4:0]        row,
        input logic [4:0]        col,
        input logic signed [4:0] value
    );
        t_cell_result res;
        int           r;
        int           c;
        res = '0;
        r   = int'(row);
        c   = int'(col);
        if (op != OP_RESV && r < ROWS && c < COLS) begin
            case (op)
                OP_WRITE: begin
                    if (value < 0)
                        grains[r][c] = WALL;
                    else if (int'(value) > STABLE_LIMIT)
                        grains[r][c] = STABLE_LIMIT;
                    else
                        grains[r][c] = int'(value);
                end
                OP_DROP: begin
                    if (grains[r][c] != WALL) begin
                        grains[r][c]++;
                        res.topple_count = settle_grid();
                    end
                end
                default: ;
            endcase
            res.cell_value = 5'(grains[r][c]);
        end
        return res;
    endfunction

    // Predict on every command transfer, check every result strobe
    always @(posedge i_clk) begin : watch_transfers
        t_cell_result want;
        if (!i_rst_n) begin
            clear_grid();
            awaited_results.delete();
        end else begin
            if (i_start && !i_busy) begin
                awaited_results.push_back(
                    apply_cell_op(i_operation, i_row, i_col, i_write_value));
            end
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding (cell %0d count %0d)",
                                              i_cell_value, i_topple_count));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_cell_value !== want.cell_value)
                        report_mismatch($sformatf("cell_value got %0d expected %0d",
                                                  i_cell_value, want.cell_value));
                    if (i_topple_count !== want.topple_count)
                        report_mismatch($sformatf("topple_count got %0d expected %0d",
                                                  i_topple_count, want.topple_count));
                end
            end
        end
        awaited_count <= awaited_results.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Command stimulus for the sandpile toppler: directed corner, wall and
// cascade cases, then random clusters of near-full cells hit by drops, mixed
// with random noise commands, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgdt_pkg::*;

    localparam int ROWS        = 32;
    localparam int COLS        = 32;
    localparam int ITEM_TARGET = 290;

    localparam logic signed [4:0] WALL_CODE   = -5'sd1;
    localparam logic signed [4:0] MOST_NEG    = 5'sb10000;
    localparam logic signed [4:0] ABOVE_RANGE = 5'sd15;
    localparam logic signed [4:0] FULL_CELL   = 5'sd8;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic [1:0]         i_operation   = OP_READ;
    logic [4:0]         i_row         = '0;
    logic [4:0]         i_col         = '0;
    logic signed [4:0]  i_write_value = '0;
    logic               busy;
    logic               o_valid;
    logic signed [4:0]  o_cell_value;
    logic [19:0]        o_topple_count;

    int fail_count;
    int pending;
    int burst_left = 0;
    int issued     = 0;

    sandpile_grain_drop_toppler #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_write_value  (i_write_value),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_cell_value   (o_cell_value),
        .o_topple_count (o_topple_count)
    );

    sgdt_cell_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cell_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_write_value  (i_write_value),
        .i_valid        (o_valid),
        .i_cell_value   (o_cell_value),
        .i_topple_count (o_topple_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic issue_cell_op(
        input logic [1:0]        op,
        input logic [4:0]        row,
        input logic [4:0]        col,
        input logic signed [4:0] value
    );
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        i_operation   <= op;
        i_row         <= row;
        i_col         <= col;
        i_write_value <= value;
        // busy only moves on rising edges, so it is settled here
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        issued++;
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random cell next to a center, clamped to the grid
    function automatic logic [4:0] near_index(input int center, input int span);
        int idx;
        idx = center + int'($urandom_range(0, 2)) - 1;
        if (idx < 0) idx = 0;
        if (idx > span - 1) idx = span - 1;
        return 5'(idx);
    endfunction

    // Load a small patch with nearly full cells, then drop grains into it
    task automatic load_and_drop_cluster();
        int                r0;
        int                c0;
        int                pick;
        logic signed [4:0] v;
        r0 = $urandom_range(0, ROWS - 1);
        c0 = $urandom_range(0, COLS - 1);
        repeat ($urandom_range(2, 7)) begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                v = 5'($urandom_range(16, 31));
            else if (pick == 1)
                v = 5'($urandom_range(9, 15));
            else
                v = 5'($urandom_range(6, 8));
            issue_cell_op(OP_WRITE, near_index(r0, ROWS), near_index(c0, COLS), v);
        end
        repeat ($urandom_range(1, 3))
            issue_cell_op(OP_DROP, near_index(r0, ROWS), near_index(c0, COLS), 5'($urandom));
        issue_cell_op(OP_READ, near_index(r0, ROWS), near_index(c0, COLS), 5'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corner topple with grains lost off the edge
        issue_cell_op(OP_READ,  5'd0,  5'd0,  5'sd0);
        issue_cell_op(OP_WRITE, 5'd0,  5'd0,  FULL_CELL);
        issue_cell_op(OP_WRITE, 5'd0,  5'd1,  ABOVE_RANGE);
        issue_cell_op(OP_WRITE, 5'd0,  5'd31, 5'sd0);
        issue_cell_op(OP_DROP,  5'd0,  5'd0,  5'sd0);
        // Walls: both ends of the negative range, drop on a wall, drop beside walls
        issue_cell_op(OP_WRITE, 5'd31, 5'd31, WALL_CODE);
        issue_cell_op(OP_WRITE, 5'd31, 5'd30, MOST_NEG);
        issue_cell_op(OP_DROP,  5'd31, 5'd31, 5'sd0);
        issue_cell_op(OP_READ,  5'd31, 5'd30, 5'sd0);
        issue_cell_op(OP_DROP,  5'd31, 5'd29, 5'sd0);
        // Unused operation code
        issue_cell_op(OP_RESV,  5'd5,  5'd5,  5'sd7);
        // Full 3x3 patch in the middle, then a grain at its center
        for (int r = 15; r <= 17; r++)
            for (int c = 15; c <= 17; c++)
                issue_cell_op(OP_WRITE, 5'(r), 5'(c), FULL_CELL);
        issue_cell_op(OP_DROP,  5'd16, 5'd16, 5'sd0);
        issue_cell_op(OP_READ,  5'd15, 5'd15, 5'sd0);
        issue_cell_op(OP_WRITE, 5'd20, 5'd10, 5'sd7);
        issue_cell_op(OP_READ,  5'd20, 5'd10, 5'sd0);

        drain_results();
        @(negedge i_clk);

        // Random: mostly drop clusters, some raw noise commands
        while (issued < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) begin
                load_and_drop_cluster();
            end else begin
                repeat ($urandom_range(1, 4))
                    issue_cell_op(2'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_results();
                @(negedge i_clk);
            end
        end

        drain_results();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
